// ===== rtl/cti_pkg.sv =====
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants for the calibration table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package cti_pkg;

    localparam int MUL_STEPS = 33;
    localparam int DIV_STEPS = 66;
    localparam int STEP_W    = 7;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_V2T   = 2'd2;
    localparam logic [1:0] OP_T2V   = 2'd3;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FEW  = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_FLAT = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       ins_step;
        logic       ins_zero;
        logic       lat_p1;
        logic       lat_p2;
        logic       mul_start;
        logic       mul_step;
        logic       div_step;
        logic       fin;
        logic       fin_calc;
        logic [2:0] stat;
    } t_cmd;

    typedef struct packed {
        logic vt_done;
        logic tv_done;
        logic key_gt;
        logic flat;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/calibration_table_interpolator.sv =====
// Clear and a load into a full table go straight to the result.
// Load: each entry with a greater key is shifted up one slot (a read, then a
// write) until the new point drops into place in both tables.
// Conversion: upper-bound scan over the entries, then 33 multiply and 66
// divide steps; one in flight.
// Synchronous active-low reset empties the table; RAM contents are kept.
// ----------------------------------------------------------------------------
// calibration_table_interpolator
// Piecewise linear voltage/temperature conversion over a sorted point table.
// ----------------------------------------------------------------------------
`default_nettype none
module calibration_table_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [63:0]  s_axis_tdata,   // voltage[31:0], temperature[63:32]
    input  wire [1:0]   s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result[31:0]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    localparam int AW = $clog2(MAX_POINTS);

    cti_pkg::t_cmd w_cmd;
    cti_pkg::t_sts w_sts;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr, w_wr_addr;

    cti_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_op      (s_axis_tuser),
        .o_ready   (s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr)
    );

    cti_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (s_axis_tuser),
        .i_voltage     (s_axis_tdata[31:0]),
        .i_temperature (s_axis_tdata[63:32]),
        .i_cmd         (w_cmd),
        .i_rd_en       (w_rd_en),
        .i_rd_addr     (w_rd_addr),
        .i_wr_addr     (w_wr_addr),
        .o_sts         (w_sts),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result      (m_axis_tdata),
        .o_status      (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/cti_ram.sv =====
// ----------------------------------------------------------------------------
// cti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire                       i_re,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cti_ctrl.sv =====
// ----------------------------------------------------------------------------
// cti_ctrl
// Sequencer: insertion shift, upper-bound scan, serial multiply and divide.
// ----------------------------------------------------------------------------
`default_nettype none
module cti_ctrl #(
    parameter int MAX_POINTS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  wire [1:0]                       i_op,
    output logic                            o_ready,
    input  wire cti_pkg::t_sts              i_sts,
    output cti_pkg::t_cmd                   o_cmd,
    output logic                            o_rd_en,
    output logic [$clog2(MAX_POINTS)-1:0]   o_rd_addr,
    output logic [$clog2(MAX_POINTS)-1:0]   o_wr_addr
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RD   = 4'd1;
    localparam logic [3:0] S_INS_WR   = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CMP = 4'd4;
    localparam logic [3:0] S_CLAMP    = 4'd5;
    localparam logic [3:0] S_P1       = 4'd6;
    localparam logic [3:0] S_P2       = 4'd7;
    localparam logic [3:0] S_CALC     = 4'd8;
    localparam logic [3:0] S_MUL      = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;

    logic [3:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_j, n_j;
    logic [cti_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic [2:0]                r_stat, n_stat;
    logic                      r_calc, n_calc;
    logic [CW-1:0]             w_idx;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        if (r_j >= r_count) begin
            w_idx = r_count - CW'(1);
        end else if (r_j == '0) begin
            w_idx = CW'(1);
        end else begin
            w_idx = r_j;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_j       = r_j;
        n_cnt     = r_cnt;
        n_stat    = r_stat;
        n_calc    = r_calc;
        o_cmd     = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_wr_addr = r_j[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_stat = cti_pkg::ST_OK;
                    n_calc = 1'b0;
                    unique case (i_op)
                        cti_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_FIN;
                        end
                        cti_pkg::OP_LOAD: begin
                            if (r_count >= CW'(MAX_POINTS)) begin
                                n_stat  = cti_pkg::ST_FULL;
                                n_state = S_FIN;
                            end else begin
                                n_j     = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        default: begin
                            if (r_count < CW'(2)) begin
                                n_stat  = cti_pkg::ST_FEW;
                                n_state = S_FIN;
                            end else begin
                                n_j     = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_sts.vt_done && i_sts.tv_done) begin
                    n_count = r_count + CW'(1);
                    n_state = S_FIN;
                end else if (r_j == '0) begin
                    o_cmd.ins_zero = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_FIN;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(r_j - CW'(1));
                    n_state   = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.ins_step = 1'b1;
                n_j     = r_j - CW'(1);
                n_state = S_INS_RD;
            end
            S_SCAN_RD: begin
                if (r_j == r_count) begin
                    n_state = S_CLAMP;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_j[AW-1:0];
                    n_state   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.key_gt) begin
                    n_state = S_CLAMP;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_CLAMP: begin
                o_rd_en   = 1'b1;
                o_rd_addr = AW'(w_idx - CW'(1));
                n_j       = w_idx;
                n_state   = S_P1;
            end
            S_P1: begin
                o_cmd.lat_p1 = 1'b1;
                o_rd_en      = 1'b1;
                o_rd_addr    = r_j[AW-1:0];
                n_state      = S_P2;
            end
            S_P2: begin
                o_cmd.lat_p2 = 1'b1;
                n_state      = S_CALC;
            end
            S_CALC: begin
                if (i_sts.flat) begin
                    n_stat  = cti_pkg::ST_FLAT;
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + cti_pkg::STEP_W'(1);
                if (r_cnt == cti_pkg::STEP_W'(cti_pkg::MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + cti_pkg::STEP_W'(1);
                if (r_cnt == cti_pkg::STEP_W'(cti_pkg::DIV_STEPS - 1)) begin
                    n_calc  = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.stat     = r_stat;
                o_cmd.fin_calc = r_calc;
                if (!i_sts.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_stat  <= cti_pkg::ST_OK;
            r_calc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
            r_stat  <= n_stat;
            r_calc  <= n_calc;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cti_dpath.sv =====
// ----------------------------------------------------------------------------
// cti_dpath
// Point tables, segment registers, shift-add multiplier, restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module cti_dpath #(
    parameter int MAX_POINTS = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire [1:0]                       i_op,
    input  wire [31:0]                      i_voltage,
    input  wire [31:0]                      i_temperature,
    input  wire cti_pkg::t_cmd              i_cmd,
    input  wire                             i_rd_en,
    input  wire [$clog2(MAX_POINTS)-1:0]    i_rd_addr,
    input  wire [$clog2(MAX_POINTS)-1:0]    i_wr_addr,
    output cti_pkg::t_sts                   o_sts,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [31:0]                     o_result,
    output logic [2:0]                      o_status
);

    logic [1:0]  r_op;
    logic [31:0] r_v, r_t;
    logic        r_vt_done, r_tv_done;
    logic [31:0] r_x1, r_y1, r_x2, r_y2;
    logic [65:0] r_ma, r_prod;
    logic [32:0] r_mb, r_rem, r_dv;
    logic        r_neg;
    logic        r_valid;
    logic [31:0] r_result;
    logic [2:0]  r_status;

    logic [63:0] w_vt_rd, w_tv_rd, w_vt_wd, w_tv_wd, w_sel_rd;
    logic        w_vt_we, w_tv_we, w_vt_gt, w_tv_gt, w_sel;
    logic [31:0] w_x;
    logic [32:0] w_dx, w_dy, w_d;
    logic [33:0] w_trial;
    logic        w_sat;
    logic [35:0] w_sum;

    cti_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_vt_ram (
        .i_clk   (i_clk),
        .i_we    (w_vt_we),
        .i_waddr (i_wr_addr),
        .i_wdata (w_vt_wd),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_vt_rd)
    );

    cti_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_tv_ram (
        .i_clk   (i_clk),
        .i_we    (w_tv_we),
        .i_waddr (i_wr_addr),
        .i_wdata (w_tv_wd),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_tv_rd)
    );

    assign w_vt_gt  = $signed(w_vt_rd[63:32]) > $signed(r_v);
    assign w_tv_gt  = $signed(w_tv_rd[63:32]) > $signed(r_t);
    assign w_sel    = (r_op == cti_pkg::OP_T2V);
    assign w_sel_rd = w_sel ? w_tv_rd : w_vt_rd;
    assign w_x      = w_sel ? r_t : r_v;

    // shift an entry up while its key is greater, else drop the new point in
    always_comb begin
        w_vt_we = 1'b0;
        w_tv_we = 1'b0;
        w_vt_wd = {r_v, r_t};
        w_tv_wd = {r_t, r_v};
        if (!r_vt_done && (i_cmd.ins_zero || i_cmd.ins_step)) begin
            w_vt_we = 1'b1;
            if (i_cmd.ins_step && w_vt_gt) begin
                w_vt_wd = w_vt_rd;
            end
        end
        if (!r_tv_done && (i_cmd.ins_zero || i_cmd.ins_step)) begin
            w_tv_we = 1'b1;
            if (i_cmd.ins_step && w_tv_gt) begin
                w_tv_wd = w_tv_rd;
            end
        end
    end

    assign w_dx = {r_x2[31], r_x2} - {r_x1[31], r_x1};
    assign w_dy = {r_y2[31], r_y2} - {r_y1[31], r_y1};
    assign w_d  = {w_x[31], w_x} - {r_x1[31], r_x1};

    assign w_trial = {r_rem, r_prod[65]};
    assign w_sat   = (|r_prod[65:34]) || (r_prod[33] && (|r_prod[32:0]));
    assign w_sum   = r_neg ? ({{4{r_y1[31]}}, r_y1} - {2'b00, r_prod[33:0]})
                           : ({{4{r_y1[31]}}, r_y1} + {2'b00, r_prod[33:0]});

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_v  <= i_voltage;
            r_t  <= i_temperature;
        end
        if (i_cmd.lat_p1) begin
            r_x1 <= w_sel_rd[63:32];
            r_y1 <= w_sel_rd[31:0];
        end
        if (i_cmd.lat_p2) begin
            r_x2 <= w_sel_rd[63:32];
            r_y2 <= w_sel_rd[31:0];
        end
        if (i_cmd.mul_start) begin
            r_ma   <= {33'd0, (w_dy[32] ? -w_dy : w_dy)};
            r_mb   <= w_d[32] ? -w_d : w_d;
            r_dv   <= w_dx[32] ? -w_dx : w_dx;
            r_neg  <= w_dy[32] ^ w_d[32] ^ w_dx[32];
            r_prod <= '0;
            r_rem  <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_prod <= r_prod + r_ma;
            end
            r_ma <= {r_ma[64:0], 1'b0};
            r_mb <= {1'b0, r_mb[32:1]};
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, r_dv}) begin
                r_rem  <= 33'(w_trial - {1'b0, r_dv});
                r_prod <= {r_prod[64:0], 1'b1};
            end else begin
                r_rem  <= w_trial[32:0];
                r_prod <= {r_prod[64:0], 1'b0};
            end
        end
        if (i_cmd.fin) begin
            if (!i_cmd.fin_calc) begin
                r_result <= '0;
                r_status <= i_cmd.stat;
            end else if (w_sat) begin
                r_status <= cti_pkg::ST_SAT;
                r_result <= r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (($signed(w_sum) > $signed(36'sh07FFFFFFF))
                    || ($signed(w_sum) < -$signed(36'sh080000000))) begin
                r_status <= cti_pkg::ST_SAT;
                r_result <= w_sum[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                r_status <= cti_pkg::ST_OK;
                r_result <= w_sum[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_vt_done <= 1'b0;
            r_tv_done <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.capture) begin
                r_vt_done <= 1'b0;
                r_tv_done <= 1'b0;
            end else if (i_cmd.ins_step) begin
                if (!w_vt_gt) begin
                    r_vt_done <= 1'b1;
                end
                if (!w_tv_gt) begin
                    r_tv_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.vt_done  = r_vt_done;
    assign o_sts.tv_done  = r_tv_done;
    assign o_sts.key_gt   = w_sel ? w_tv_gt : w_vt_gt;
    assign o_sts.flat     = (r_x2 == r_x1);
    assign o_sts.out_busy = r_valid && !i_ready;

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_status = r_status;

endmodule
`default_nettype wire
